### rtl/dnsap_pkg.sv
// shared types and constants for the dns a-record response parser
package dnsap_pkg;

   localparam int unsigned DataWidth     = 8;
   localparam int unsigned AddrWidth     = 32;
   localparam int unsigned PortWidth     = 16;
   localparam int unsigned WordWidth     = 16;
   localparam int unsigned PosWidth      = 4;
   localparam int unsigned LabelWidth    = 6;
   localparam int unsigned OutcomeWidth  = 2;
   localparam int unsigned ReqDataWidth  = 56;
   localparam int unsigned RspDataWidth  = 40;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [PortWidth-1:0]  DnsPort      = 16'd53;
   localparam logic [WordWidth-1:0]  QrMask       = 16'h8000;
   localparam logic [WordWidth-1:0]  RcodeMask    = 16'h000F;
   localparam logic [DataWidth-1:0]  PointerMask  = 8'hC0;
   localparam logic [DataWidth-1:0]  MaxLabelLen  = 8'd63;
   localparam logic [WordWidth-1:0]  TypeA        = 16'd1;
   localparam logic [WordWidth-1:0]  ClassIn      = 16'd1;
   localparam logic [WordWidth-1:0]  Ipv4Len      = 16'd4;

   // byte positions inside the fixed header and the fixed part of a record
   localparam logic [PosWidth-1:0] PosIdLo      = 4'd1;
   localparam logic [PosWidth-1:0] PosFlagsLo   = 4'd3;
   localparam logic [PosWidth-1:0] PosQdLo      = 4'd5;
   localparam logic [PosWidth-1:0] PosAnLo      = 4'd7;
   localparam logic [PosWidth-1:0] PosHeaderEnd = 4'd11;
   localparam logic [PosWidth-1:0] PosQfixEnd   = 4'd3;
   localparam logic [PosWidth-1:0] PosTypeLo    = 4'd1;
   localparam logic [PosWidth-1:0] PosClassLo   = 4'd3;
   localparam logic [PosWidth-1:0] PosAfixEnd   = 4'd9;
   localparam logic [PosWidth-1:0] PosPointer   = 4'd1;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrServerIp   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrExpectedId = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrArmed      = 2'd2;

   // rsp_tdata layout
   localparam int unsigned RspOutcomeLsb = 0;
   localparam int unsigned RspAddrLsb    = 2;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_QNAME  = 3'd1,
      PH_QFIXED = 3'd2,
      PH_ANAME  = 3'd3,
      PH_AFIXED = 3'd4,
      PH_RDATA  = 3'd5,
      PH_DONE   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      V_PENDING  = 2'd0,
      V_RESOLVED = 2'd1,
      V_FAILED   = 2'd2
   } verdict_type;

   typedef enum logic [OutcomeWidth-1:0] {
      OUTCOME_IGNORED  = 2'd0,
      OUTCOME_RESOLVED = 2'd1,
      OUTCOME_FAILED   = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [AddrWidth-1:0] server_ip;
      logic [WordWidth-1:0] expected_id;
      logic                 armed;
   } cfg_type;

   typedef struct packed {
      outcome_type          outcome;
      logic [AddrWidth-1:0] ipv4_result;
   } result_type;

endpackage

### rtl/dns_a_response_parser_core.sv
// top level of the dns a-record response parser: csr registers, parser, result register
// one payload byte per req transfer, one byte accepted every cycle unless req stalls
// the result of a packet is registered and appears on rsp in the cycle after the transfer of its last byte
// req stalls only while a result is held and rsp_tready is low
// synchronous active-high reset clears the csr registers, parse state, settled flag
// and the valid flag of the result register; the result data itself is not reset
module dns_a_response_parser_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dnsap_pkg::ReqDataWidth-1:0]   req_tdata,  // data_byte, sender_address, sender_port
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dnsap_pkg::RspDataWidth-1:0]   rsp_tdata,  // outcome, ipv4_result, zero pad
   input  logic                                 csr_wen,
   input  logic [dnsap_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [dnsap_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import dnsap_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       clear_settled;
   logic       byte_fire;
   logic       result_valid;
   result_type result;
   logic       space_ok;

   always_comb begin
      cfg_in        = cfg_ff;
      clear_settled = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            CsrServerIp:   cfg_in.server_ip   = csr_wdata[AddrWidth-1:0];
            CsrExpectedId: cfg_in.expected_id = csr_wdata[WordWidth-1:0];
            CsrArmed: begin
               cfg_in.armed  = csr_wdata[0];
               clear_settled = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = space_ok;
   assign byte_fire  = req_tvalid && req_tready;

   dnsap_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .clear_settled  (clear_settled),
      .byte_fire      (byte_fire),
      .data_byte      (req_tdata[7:0]),
      .last_byte      (req_tlast),
      .sender_address (req_tdata[39:8]),
      .sender_port    (req_tdata[55:40]),
      .result_valid   (result_valid),
      .result         (result)
   );

   dnsap_out u_out (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .space_ok     (space_ok)
   );

   // a held result that rsp does not take blocks the next byte
   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while a result is held");

   // a new result only follows a last-byte transfer
   a_result_after_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result without a last byte");

   // address is zero unless resolved
   a_addr_only_resolved : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RspAddrLsb-1:RspOutcomeLsb] != OUTCOME_RESOLVED
         |-> rsp_tdata[RspAddrLsb +: AddrWidth] == '0)
      else $error("address given without resolution");

   a_outcome_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspAddrLsb-1:RspOutcomeLsb] != 2'b11)
      else $error("undefined outcome code");

endmodule

### rtl/dnsap_parser.sv
// byte-wide parse state machine: header, questions, answers and verdict
module dnsap_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  dnsap_pkg::cfg_type            cfg,
   input  logic                          clear_settled,
   input  logic                          byte_fire,
   input  logic [dnsap_pkg::DataWidth-1:0] data_byte,
   input  logic                          last_byte,
   input  logic [dnsap_pkg::AddrWidth-1:0] sender_address,
   input  logic [dnsap_pkg::PortWidth-1:0] sender_port,
   output logic                          result_valid,
   output dnsap_pkg::result_type         result
);
   import dnsap_pkg::*;

   phase_type              phase_ff,    phase_in;
   logic [PosWidth-1:0]    pos_ff,      pos_in;
   logic                   drop_ff,     drop_in;
   logic [WordWidth-1:0]   word_ff,     word_in;
   logic [WordWidth-1:0]   qleft_ff,    qleft_in;
   logic [WordWidth-1:0]   aleft_ff,    aleft_in;
   logic [LabelWidth-1:0]  label_ff,    label_in;
   logic [WordWidth-1:0]   rtype_ff,    rtype_in;
   logic [WordWidth-1:0]   rclass_ff,   rclass_in;
   logic [WordWidth-1:0]   rdleft_ff,   rdleft_in;
   logic [AddrWidth-1:0]   addr_ff,     addr_in;
   verdict_type            verdict_ff,  verdict_in;
   logic                   settled_ff,  settled_in;

   logic [WordWidth-1:0]   word_next;
   logic [WordWidth-1:0]   q_dec;
   logic [WordWidth-1:0]   a_dec;
   logic [WordWidth-1:0]   rd_dec;
   phase_type              name_next;

   assign word_next = {word_ff[WordWidth-DataWidth-1:0], data_byte};
   assign q_dec     = qleft_ff - 1'b1;
   assign a_dec     = aleft_ff - 1'b1;
   assign rd_dec    = rdleft_ff - 1'b1;
   assign name_next = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      drop_in      = drop_ff;
      word_in      = word_ff;
      qleft_in     = qleft_ff;
      aleft_in     = aleft_ff;
      label_in     = label_ff;
      rtype_in     = rtype_ff;
      rclass_in    = rclass_ff;
      rdleft_in    = rdleft_ff;
      addr_in      = addr_ff;
      verdict_in   = verdict_ff;
      settled_in   = clear_settled ? 1'b0 : settled_ff;
      result_valid = 1'b0;
      result       = '{outcome: OUTCOME_IGNORED, ipv4_result: '0};

      if (byte_fire) begin
         if (!cfg.armed || settled_ff || sender_address != cfg.server_ip ||
             sender_port != DnsPort) begin
            drop_in = 1'b1;
         end
         if (!drop_in) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  word_in = word_next;
                  if (pos_ff == PosIdLo && word_next != cfg.expected_id) begin
                     drop_in = 1'b1;
                  end
                  if (pos_ff == PosFlagsLo &&
                      ((word_next & QrMask) == '0 || (word_next & RcodeMask) != '0)) begin
                     verdict_in = V_FAILED;
                  end
                  if (pos_ff == PosQdLo) qleft_in = word_next;
                  if (pos_ff == PosAnLo) aleft_in = word_next;
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff == PosHeaderEnd) begin
                     pos_in = '0;
                     if (verdict_in == V_FAILED) begin
                        phase_in = PH_DONE;
                     end else if (qleft_ff != '0) begin
                        phase_in = PH_QNAME;
                     end else if (aleft_ff == '0) begin
                        verdict_in = V_FAILED;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_ANAME;
                        label_in = '0;
                     end
                  end
               end
               PH_QNAME, PH_ANAME: begin
                  if (pos_ff == PosPointer) begin
                     // second byte of a compression pointer ends the name
                     pos_in   = '0;
                     phase_in = name_next;
                  end else if (label_ff != '0) begin
                     label_in = label_ff - 1'b1;
                  end else if (data_byte == '0) begin
                     pos_in   = '0;
                     phase_in = name_next;
                  end else if ((data_byte & PointerMask) == PointerMask) begin
                     pos_in = PosPointer;
                  end else if (data_byte > MaxLabelLen) begin
                     verdict_in = V_FAILED;
                     phase_in   = PH_DONE;
                  end else begin
                     label_in = data_byte[LabelWidth-1:0];
                  end
               end
               PH_QFIXED: begin
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff == PosQfixEnd) begin
                     pos_in   = '0;
                     qleft_in = q_dec;
                     if (q_dec != '0) begin
                        phase_in = PH_QNAME;
                     end else if (aleft_ff == '0) begin
                        verdict_in = V_FAILED;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_ANAME;
                        label_in = '0;
                     end
                  end
               end
               PH_AFIXED: begin
                  word_in = word_next;
                  if (pos_ff == PosTypeLo)  rtype_in  = word_next;
                  if (pos_ff == PosClassLo) rclass_in = word_next;
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff == PosAfixEnd) begin
                     pos_in    = '0;
                     rdleft_in = word_next;
                     addr_in   = '0;
                     // only an in-class a record of four bytes keeps its type
                     if (!(rtype_ff == TypeA && rclass_ff == ClassIn && word_next == Ipv4Len)) begin
                        rtype_in = '0;
                     end
                     if (word_next == '0) begin
                        aleft_in = a_dec;
                        if (a_dec == '0) begin
                           verdict_in = V_FAILED;
                           phase_in   = PH_DONE;
                        end else begin
                           phase_in = PH_ANAME;
                           label_in = '0;
                        end
                     end else begin
                        phase_in = PH_RDATA;
                     end
                  end
               end
               PH_RDATA: begin
                  rdleft_in = rd_dec;
                  if (rtype_ff == TypeA) begin
                     addr_in = {addr_ff[AddrWidth-DataWidth-1:0], data_byte};
                  end
                  if (rd_dec == '0) begin
                     if (rtype_ff == TypeA) begin
                        verdict_in = V_RESOLVED;
                        phase_in   = PH_DONE;
                     end else begin
                        aleft_in = a_dec;
                        if (a_dec == '0) begin
                           verdict_in = V_FAILED;
                           phase_in   = PH_DONE;
                        end else begin
                           phase_in = PH_ANAME;
                           pos_in   = '0;
                           label_in = '0;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (last_byte) begin
            result_valid = 1'b1;
            // a packet still in its header is too short to count
            if (!drop_in && phase_in != PH_HEADER) begin
               if (verdict_in == V_RESOLVED) begin
                  result.outcome     = OUTCOME_RESOLVED;
                  result.ipv4_result = addr_in;
               end else begin
                  result.outcome = OUTCOME_FAILED;
               end
               settled_in = 1'b1;
            end
            phase_in   = PH_HEADER;
            pos_in     = '0;
            drop_in    = 1'b0;
            word_in    = '0;
            qleft_in   = '0;
            aleft_in   = '0;
            label_in   = '0;
            rtype_in   = '0;
            rclass_in  = '0;
            rdleft_in  = '0;
            addr_in    = '0;
            verdict_in = V_PENDING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         drop_ff    <= 1'b0;
         word_ff    <= '0;
         qleft_ff   <= '0;
         aleft_ff   <= '0;
         label_ff   <= '0;
         rtype_ff   <= '0;
         rclass_ff  <= '0;
         rdleft_ff  <= '0;
         addr_ff    <= '0;
         verdict_ff <= V_PENDING;
         settled_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         drop_ff    <= drop_in;
         word_ff    <= word_in;
         qleft_ff   <= qleft_in;
         aleft_ff   <= aleft_in;
         label_ff   <= label_in;
         rtype_ff   <= rtype_in;
         rclass_ff  <= rclass_in;
         rdleft_ff  <= rdleft_in;
         addr_ff    <= addr_in;
         verdict_ff <= verdict_in;
         settled_ff <= settled_in;
      end
   end

endmodule

### rtl/dnsap_out.sv
// result register between the parser and the rsp channel
module dnsap_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                result_valid,
   input  dnsap_pkg::result_type               result,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dnsap_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                                space_ok
);
   import dnsap_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   // the register frees up in the same cycle its result is taken
   assign space_ok = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (result_valid) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - OutcomeWidth - AddrWidth){1'b0}},
                        data_ff.ipv4_result, data_ff.outcome};

endmodule
